// ----- rtl/core/tcnp_pkg.sv -----
`timescale 1ns / 1ps
package tcnp_pkg;
	localparam int MaxNodesDef = 256;
	localparam int NodeIdBitsDef = 10;
	localparam int LoadBitsDef = 16;
	localparam int RandBitsDef = 16;
	localparam int CfgBits = 9;
	localparam int CmdBits = 2;
	localparam int StatusBits = 3;

	typedef enum logic [CmdBits-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_START = 2'd2,
		CMD_PICK = 2'd3
	} cmd_t;

	typedef enum logic [StatusBits-1:0] {
		ST_OK = 3'd0,
		ST_PRESENT = 3'd1,
		ST_ABSENT = 3'd2,
		ST_FULL = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MAPRD,
		S_DECIDE,
		S_RDLAST,
		S_MOVE,
		S_DIV,
		S_RD1,
		S_RD2,
		S_CMP,
		S_SWAP,
		S_OUT
	} state_t;
endpackage

// ----- rtl/core/tcnp_if.sv -----
`timescale 1ns / 1ps
interface tcnp_in_if #(
	parameter int NODE_ID_BITS = 10,
	parameter int LOAD_BITS = 16,
	parameter int RAND_BITS = 16
);
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [NODE_ID_BITS-1:0] node_id;
	logic [LOAD_BITS-1:0] load;
	logic [RAND_BITS-1:0] rand_first;
	logic [RAND_BITS-1:0] rand_second;
	modport source (output valid, cmd, node_id, load, rand_first, rand_second, input ready);
	modport sink (input valid, cmd, node_id, load, rand_first, rand_second, output ready);
endinterface

interface tcnp_out_if #(
	parameter int NODE_ID_BITS = 10
);
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [NODE_ID_BITS-1:0] picked_node;
	logic [8:0] node_count;
	logic session_exhausted;
	modport source (output valid, status, picked_node, node_count, session_exhausted,
		input ready);
	modport sink (input valid, status, picked_node, node_count, session_exhausted,
		output ready);
endinterface

// ----- rtl/core/tcnp_divider.sv -----
`timescale 1ns / 1ps
module tcnp_divider import tcnp_pkg::*; #(
	parameter int RAND_BITS = RandBitsDef,
	parameter int SPAN_BITS = 9
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [RAND_BITS-1:0] dividend_a,
	input logic [RAND_BITS-1:0] dividend_b,
	input logic [SPAN_BITS-1:0] divisor,
	output logic done,
	output logic [SPAN_BITS-1:0] rem_a,
	output logic [SPAN_BITS-1:0] rem_b
);
	localparam int CntBits = $clog2(RAND_BITS + 1);
	localparam int RemBits = SPAN_BITS + 1;

	logic [CntBits-1:0] cnt_q;
	logic busy_q;
	logic [RAND_BITS-1:0] qa_q, qb_q;
	logic [RemBits-1:0] ra_q, rb_q;
	logic [RemBits-1:0] ta, tb;

	assign ta = {ra_q[SPAN_BITS-1:0], qa_q[RAND_BITS-1]};
	assign tb = {rb_q[SPAN_BITS-1:0], qb_q[RAND_BITS-1]};
	assign done = busy_q && (cnt_q == '0);
	assign rem_a = ra_q[SPAN_BITS-1:0];
	assign rem_b = rb_q[SPAN_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CntBits'(RAND_BITS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qa_q <= dividend_a;
			qb_q <= dividend_b;
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			qa_q <= {qa_q[RAND_BITS-2:0], 1'b0};
			qb_q <= {qb_q[RAND_BITS-2:0], 1'b0};
			ra_q <= (ta >= {1'b0, divisor}) ? ta - {1'b0, divisor} : ta;
			rb_q <= (tb >= {1'b0, divisor}) ? tb - {1'b0, divisor} : tb;
		end
	end
endmodule

// ----- rtl/core/tcnp_table.sv -----
`timescale 1ns / 1ps
module tcnp_table import tcnp_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/two_choice_node_picker.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_ch    in   cmd, node_id, load, rand_first, rand_second
// out_ch   out  status, picked_node, node_count, session_exhausted
// cfg      in   cfg_we, cfg_data (check_limit)
// The pick time is set by the bit-serial modulo unit and the memories with one read
// port each. After reset a clearing pass empties the map; no beat is taken meanwhile.
// A stalled result holds the block until it is taken.
module two_choice_node_picker import tcnp_pkg::*; #(
	parameter int MAX_NODES = MaxNodesDef,
	parameter int NODE_ID_BITS = NodeIdBitsDef,
	parameter int LOAD_BITS = LoadBitsDef,
	parameter int RAND_BITS = RandBitsDef
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CfgBits-1:0] cfg_data,
	tcnp_in_if.sink in_ch,
	tcnp_out_if.source out_ch
);
	localparam int PB = $clog2(MAX_NODES);
	localparam int CB = $clog2(MAX_NODES + 1);
	localparam int IDS = 1 << NODE_ID_BITS;
	localparam int MW = PB + 1;

	state_t state_q, state_d;
	logic [CfgBits-1:0] limit_q;
	logic [CB-1:0] count_q, checked_q, budget_q;
	logic [1:0] cmd_q;
	logic [NODE_ID_BITS-1:0] id_q, moved_q, n1_q;
	logic [LOAD_BITS-1:0] load_q, l1_q;
	logic [RAND_BITS-1:0] r1_q, r2_q;
	logic [PB-1:0] pos_q, i1_q, i2_q, win_q;
	logic [NODE_ID_BITS-1:0] clr_q;
	logic [2:0] status_q;
	logic [NODE_ID_BITS-1:0] picked_q;
	logic step_q;
	logic [CB-1:0] span;

	logic nwe, lwe, mwe;
	logic [PB-1:0] naddr_w, nraddr, laddr_w, lraddr;
	logic [NODE_ID_BITS-1:0] nwdata, nrdata;
	logic [LOAD_BITS-1:0] lwdata, lrdata;
	logic [NODE_ID_BITS-1:0] maddr_w, mraddr;
	logic [MW-1:0] mwdata, mrdata;

	logic div_start, div_done;
	logic [PB:0] rem_a, rem_b;

	tcnp_table #(.DEPTH(MAX_NODES), .WIDTH(NODE_ID_BITS)) u_node (
		.clk, .we(nwe), .waddr(naddr_w), .wdata(nwdata), .raddr(nraddr), .rdata(nrdata));
	tcnp_table #(.DEPTH(MAX_NODES), .WIDTH(LOAD_BITS)) u_load (
		.clk, .we(lwe), .waddr(laddr_w), .wdata(lwdata), .raddr(lraddr), .rdata(lrdata));
	tcnp_table #(.DEPTH(IDS), .WIDTH(MW)) u_map (
		.clk, .we(mwe), .waddr(maddr_w), .wdata(mwdata), .raddr(mraddr), .rdata(mrdata));
	tcnp_divider #(.RAND_BITS(RAND_BITS), .SPAN_BITS(PB + 1)) u_div (
		.clk, .arst_n, .start(div_start), .dividend_a(r1_q), .dividend_b(r2_q),
		.divisor((PB+1)'(span)), .done(div_done), .rem_a, .rem_b);

	assign span = count_q - checked_q;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.status = status_q;
	assign out_ch.picked_node = picked_q;
	assign out_ch.node_count = 9'(count_q);
	assign out_ch.session_exhausted = (checked_q >= budget_q);

	always_comb begin
		state_d = state_q;
		nwe = 1'b0; lwe = 1'b0; mwe = 1'b0;
		naddr_w = '0; nwdata = '0; laddr_w = '0; lwdata = '0;
		maddr_w = id_q; mwdata = '0;
		nraddr = '0; lraddr = '0; mraddr = id_q;
		div_start = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mwe = 1'b1;
				maddr_w = clr_q;
				if (clr_q == NODE_ID_BITS'(IDS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_ch.valid) begin
					unique case (cmd_t'(in_ch.cmd))
						CMD_START: state_d = S_OUT;
						CMD_PICK: state_d = S_DIV;
						default: state_d = S_MAPRD;
					endcase
				end
			end
			S_MAPRD: state_d = S_DECIDE;
			S_DECIDE: begin
				if (cmd_q == CMD_INSERT) begin
					state_d = S_OUT;
					if (!mrdata[PB] && count_q < CB'(MAX_NODES)) begin
						nwe = 1'b1; lwe = 1'b1; mwe = 1'b1;
						naddr_w = PB'(count_q); nwdata = id_q;
						laddr_w = PB'(count_q); lwdata = load_q;
						mwdata = {1'b1, PB'(count_q)};
					end
				end else begin
					nraddr = PB'(count_q - 1'b1);
					lraddr = PB'(count_q - 1'b1);
					state_d = (!mrdata[PB] || count_q == '0) ? S_OUT : S_RDLAST;
				end
			end
			S_RDLAST: begin
				mwe = 1'b1;
				maddr_w = nrdata;
				mwdata = {1'b1, pos_q};
				nwe = 1'b1; naddr_w = pos_q; nwdata = nrdata;
				lwe = 1'b1; laddr_w = pos_q; lwdata = lrdata;
				state_d = S_MOVE;
			end
			S_MOVE: begin
				mwe = 1'b1;
				maddr_w = id_q;
				mwdata = '0;
				state_d = S_OUT;
			end
			S_DIV: begin
				div_start = !step_q;
				if (step_q && div_done) state_d = S_RD1;
				if (!step_q && (checked_q >= budget_q || checked_q >= count_q))
					state_d = S_OUT;
			end
			S_RD1: begin
				nraddr = i1_q; lraddr = i1_q;
				state_d = S_RD2;
			end
			S_RD2: begin
				nraddr = i2_q; lraddr = i2_q;
				state_d = S_CMP;
			end
			S_CMP: begin
				nraddr = PB'(checked_q); lraddr = PB'(checked_q);
				state_d = S_SWAP;
			end
			S_SWAP: begin
				if (step_q == 1'b0) begin
					nwe = 1'b1; naddr_w = win_q; nwdata = nrdata;
					lwe = 1'b1; laddr_w = win_q; lwdata = lrdata;
					mwe = 1'b1; maddr_w = nrdata; mwdata = {1'b1, win_q};
				end else begin
					nwe = 1'b1; naddr_w = PB'(checked_q); nwdata = picked_q;
					lwe = 1'b1; laddr_w = PB'(checked_q); lwdata = l1_q;
					mwe = 1'b1; maddr_w = picked_q; mwdata = {1'b1, PB'(checked_q)};
					state_d = S_OUT;
				end
			end
			S_OUT: if (out_ch.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			limit_q <= '0;
			count_q <= '0;
			checked_q <= '0;
			budget_q <= '0;
			step_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) limit_q <= cfg_data;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			step_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid && cmd_t'(in_ch.cmd) == CMD_START) begin
						budget_q <= (CB'(limit_q) < count_q) ? CB'(limit_q) : count_q;
						checked_q <= '0;
					end
				end
				S_DECIDE: begin
					if (cmd_q == CMD_INSERT && !mrdata[PB] && count_q < CB'(MAX_NODES))
						count_q <= count_q + 1'b1;
				end
				S_MOVE: count_q <= count_q - 1'b1;
				S_DIV: step_q <= 1'b1;
				S_SWAP: begin
					step_q <= !step_q;
					if (step_q) checked_q <= checked_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= in_ch.cmd;
				id_q <= in_ch.node_id;
				load_q <= in_ch.load;
				r1_q <= in_ch.rand_first;
				r2_q <= in_ch.rand_second;
				status_q <= ST_OK;
				picked_q <= '0;
			end
			S_DECIDE: begin
				if (cmd_q == CMD_INSERT) begin
					if (mrdata[PB]) status_q <= ST_PRESENT;
					else if (count_q >= CB'(MAX_NODES)) status_q <= ST_FULL;
				end else begin
					if (!mrdata[PB] || count_q == '0) status_q <= ST_ABSENT;
					pos_q <= (CB'(mrdata[PB-1:0]) > count_q - 1'b1)
						? PB'(count_q - 1'b1) : mrdata[PB-1:0];
				end
			end
			S_DIV: begin
				if (!step_q && (checked_q >= budget_q || checked_q >= count_q))
					status_q <= ST_EMPTY;
				i1_q <= PB'(checked_q + CB'(rem_a));
				i2_q <= PB'(checked_q + CB'(rem_b));
			end
			S_RD2: begin
				n1_q <= nrdata;
				l1_q <= lrdata;
			end
			S_CMP: begin
				if (l1_q < lrdata) begin
					win_q <= i1_q;
					picked_q <= n1_q;
					moved_q <= n1_q;
				end else begin
					win_q <= i2_q;
					picked_q <= nrdata;
					l1_q <= lrdata;
					moved_q <= nrdata;
				end
			end
			S_SWAP: begin
				if (!step_q) begin
					picked_q <= moved_q;
				end
			end
			default: ;
		endcase
	end
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import tcnp_pkg::*;

	localparam int NODES = 256;
	localparam int IDS = 1024;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int SETTLE = 40;

	typedef struct {
		cmd_t cmd;
		logic [9:0] id;
		logic [15:0] ld;
		logic [15:0] r1;
		logic [15:0] r2;
	} req_t;

	typedef struct {
		status_t st;
		logic [9:0] node;
		logic [8:0] cnt;
		logic done;
	} rsp_t;

	typedef struct {
		req_t req;
		logic known;
		rsp_t rsp;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [8:0] cfg_data;

	tcnp_in_if in_ch ();
	tcnp_out_if out_ch ();

	two_choice_node_picker uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Model of the node table.
	logic [9:0] tbl_node [NODES];
	logic [15:0] tbl_load [NODES];
	int unsigned slot_of [IDS];
	bit present [IDS];
	int unsigned n_nodes;
	int unsigned n_checked;
	int unsigned budget;
	int unsigned limit_reg;

	rsp_t pending_rsp [$];
	int errors;
	int n_items;
	int n_results;
	int n_picks;
	int n_full;
	int idle_cycles;
	bit hold_request;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic rsp_t pick_model(req_t r);
		rsp_t o;
		int unsigned p;
		int unsigned last;
		int unsigned span;
		int unsigned i1;
		int unsigned i2;
		int unsigned w;
		logic [9:0] na;
		logic [15:0] la;
		o.st = ST_OK;
		o.node = '0;
		case (r.cmd)
			CMD_INSERT: begin
				if (present[r.id]) begin
					o.st = ST_PRESENT;
				end else if (n_nodes >= NODES) begin
					o.st = ST_FULL;
				end else begin
					tbl_node[n_nodes] = r.id;
					tbl_load[n_nodes] = r.ld;
					slot_of[r.id] = n_nodes;
					present[r.id] = 1'b1;
					n_nodes++;
				end
			end
			CMD_REMOVE: begin
				if (!present[r.id] || n_nodes == 0) begin
					o.st = ST_ABSENT;
				end else begin
					p = slot_of[r.id];
					last = n_nodes - 1;
					if (p > last) p = last;
					slot_of[tbl_node[last]] = p;
					tbl_node[p] = tbl_node[last];
					tbl_load[p] = tbl_load[last];
					present[r.id] = 1'b0;
					n_nodes--;
				end
			end
			CMD_START: begin
				budget = (limit_reg < n_nodes) ? limit_reg : n_nodes;
				n_checked = 0;
			end
			default: begin
				if (n_checked >= budget || n_checked >= n_nodes) begin
					o.st = ST_EMPTY;
				end else begin
					span = n_nodes - n_checked;
					i1 = n_checked + r.r1 % span;
					i2 = n_checked + r.r2 % span;
					w = (tbl_load[i1] < tbl_load[i2]) ? i1 : i2;
					o.node = tbl_node[w];
					na = tbl_node[n_checked];
					la = tbl_load[n_checked];
					slot_of[na] = w;
					slot_of[tbl_node[w]] = n_checked;
					tbl_node[n_checked] = tbl_node[w];
					tbl_load[n_checked] = tbl_load[w];
					tbl_node[w] = na;
					tbl_load[w] = la;
					n_checked++;
				end
			end
		endcase
		o.cnt = n_nodes[8:0];
		o.done = n_checked >= budget;
		return o;
	endfunction

	task automatic send(req_t r, logic known, rsp_t want);
		rsp_t got;
		in_ch.valid <= 1'b1;
		in_ch.cmd <= r.cmd;
		in_ch.node_id <= r.id;
		in_ch.load <= r.ld;
		in_ch.rand_first <= r.r1;
		in_ch.rand_second <= r.r2;
		do @(posedge clk); while (!in_ch.ready);
		got = pick_model(r);
		pending_rsp = {pending_rsp, (known ? want : got)};
		n_items++;
		if (r.cmd == CMD_PICK && got.st == ST_OK) n_picks++;
		if (got.st == ST_FULL) n_full++;
	endtask

	task automatic pause(int n);
		in_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_limit(int unsigned v);
		in_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v[8:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = v;
	endtask

	function automatic req_t make_req(int mode);
		req_t r;
		int roll;
		int c;
		roll = $urandom_range(0, 99);
		case (mode)
			0: c = roll < 85 ? 0 : (roll < 90 ? 1 : (roll < 94 ? 2 : 3));
			1: c = roll < 70 ? 1 : (roll < 80 ? 0 : (roll < 88 ? 2 : 3));
			default: c = roll < 15 ? 0 : (roll < 25 ? 1 : (roll < 35 ? 2 : 3));
		endcase
		r.cmd = cmd_t'(c);
		if (n_nodes > 0 && $urandom_range(0, 1) == 1)
			r.id = tbl_node[$urandom_range(0, n_nodes - 1)];
		else
			r.id = 10'($urandom_range(0, IDS - 1));
		case ($urandom_range(0, 3))
			0: r.ld = 16'h0000;
			1: r.ld = 16'hffff;
			2: r.ld = 16'($urandom_range(0, 3));
			default: r.ld = 16'($urandom_range(0, 65535));
		endcase
		r.r1 = 16'($urandom_range(0, 65535));
		r.r2 = ($urandom_range(0, 4) == 0) ? r.r1 : 16'($urandom_range(0, 65535));
		return r;
	endfunction

	function automatic row_t mk(cmd_t c, int id, int ld, int r1, int r2, logic k,
		status_t st, int cnt, logic dn);
		row_t w;
		w.req.cmd = c;
		w.req.id = 10'(id);
		w.req.ld = 16'(ld);
		w.req.r1 = 16'(r1);
		w.req.r2 = 16'(r2);
		w.known = k;
		w.rsp.st = st;
		w.rsp.node = '0;
		w.rsp.cnt = 9'(cnt);
		w.rsp.done = dn;
		return w;
	endfunction

	row_t early [9];
	row_t later [10];

	// Receiver: stalls in changing patterns, plus one long hold on request.
	initial begin
		int mode;
		out_ch.ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			repeat ($urandom_range(20, 200)) begin
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					2: out_ch.ready <= ($urandom_range(0, 5) == 0);
					default: out_ch.ready <= ($urandom_range(0, 5) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (out_ch.valid && out_ch.ready) begin
			n_results++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected beat status=%0d node=%0d count=%0d", $time,
					out_ch.status, out_ch.picked_node, out_ch.node_count);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (out_ch.status !== e.st || out_ch.picked_node !== e.node ||
						out_ch.node_count !== e.cnt || out_ch.session_exhausted !== e.done) begin
					$display("%0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						$time, e.st, e.node, e.cnt, e.done, out_ch.status,
						out_ch.picked_node, out_ch.node_count, out_ch.session_exhausted);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Timeout with %0d beats outstanding", pending_rsp.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int limits [10];
		int modes [10];
		int left;
		req_t r;
		rsp_t none;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_picks = 0;
		n_full = 0;
		idle_cycles = 0;
		hold_request = 1'b0;
		n_nodes = 0;
		n_checked = 0;
		budget = 0;
		limit_reg = 0;
		for (int i = 0; i < IDS; i++) present[i] = 1'b0;
		none = '{st: ST_OK, node: '0, cnt: '0, done: 1'b0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_INSERT;
		in_ch.node_id = '0;
		in_ch.load = '0;
		in_ch.rand_first = '0;
		in_ch.rand_second = '0;

		early[0] = mk(CMD_PICK, 0, 0, 0, 0, 1, ST_EMPTY, 0, 1);
		early[1] = mk(CMD_REMOVE, 5, 0, 0, 0, 1, ST_ABSENT, 0, 1);
		early[2] = mk(CMD_START, 0, 0, 0, 0, 1, ST_OK, 0, 1);
		early[3] = mk(CMD_INSERT, 0, 16'h0000, 0, 0, 1, ST_OK, 1, 1);
		early[4] = mk(CMD_INSERT, 0, 16'hffff, 0, 0, 1, ST_PRESENT, 1, 1);
		early[5] = mk(CMD_INSERT, 10'h3ff, 16'hffff, 16'hffff, 16'hffff, 1, ST_OK, 2, 1);
		early[6] = mk(CMD_INSERT, 10'h2aa, 16'h1000, 0, 0, 1, ST_OK, 3, 1);
		early[7] = mk(CMD_START, 0, 0, 0, 0, 1, ST_OK, 3, 1);
		early[8] = mk(CMD_PICK, 0, 0, 16'h5555, 16'haaaa, 1, ST_EMPTY, 3, 1);

		later[0] = mk(CMD_START, 0, 0, 0, 0, 0, ST_OK, 0, 0);
		later[1] = mk(CMD_PICK, 0, 0, 16'h0000, 16'h0000, 0, ST_OK, 0, 0);
		later[2] = mk(CMD_PICK, 0, 0, 16'hffff, 16'hffff, 0, ST_OK, 0, 0);
		later[3] = mk(CMD_PICK, 0, 0, 16'h0001, 16'h0002, 0, ST_OK, 0, 0);
		later[4] = mk(CMD_PICK, 0, 0, 16'h1234, 16'h4321, 1, ST_EMPTY, 3, 1);
		later[5] = mk(CMD_START, 0, 0, 0, 0, 0, ST_OK, 0, 0);
		later[6] = mk(CMD_REMOVE, 10'h3ff, 0, 0, 0, 0, ST_OK, 0, 0);
		later[7] = mk(CMD_INSERT, 10'h155, 16'h0000, 0, 0, 0, ST_OK, 0, 0);
		later[8] = mk(CMD_PICK, 0, 0, 16'h0003, 16'h0003, 0, ST_OK, 0, 0);
		later[9] = mk(CMD_REMOVE, 10'h155, 0, 0, 0, 0, ST_OK, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (early[i]) send(early[i].req, early[i].known, early[i].rsp);
		write_limit(256);
		foreach (later[i]) send(later[i].req, later[i].known, later[i].rsp);

		limits = '{256, 0, 3, 256, 1, 2, 255, 256, 7, 4};
		modes = '{0, 0, 2, 2, 1, 1, 2, 0, 2, 2};
		foreach (limits[ph]) begin
			write_limit(ph == 8 ? $urandom_range(0, 256) : limits[ph]);
			if (ph == 3) hold_request = 1'b1;
			left = 150;
			while (left > 0) begin
				repeat ($urandom_range(1, 20)) begin
					if (left > 0) begin
						r = make_req(modes[ph]);
						send(r, 1'b0, none);
						left--;
					end
				end
				if ($urandom_range(0, 4) != 0) pause($urandom_range(1, 15));
			end
		end

		in_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d commands, %0d results, %0d picks, %0d full refusals.",
			n_items, n_results, n_picks, n_full);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL");
		end
		$finish;
	end
endmodule
